@@ hdl/mfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfp_pkg
// types, codes and crc helpers shared by the frame parser modules
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam logic [7:0] START_V1 = 8'hFE;
    localparam logic [7:0] START_V2 = 8'hFD;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [3:0] HDR_V1 = 4'd6;
    localparam logic [3:0] HDR_V2 = 4'd10;
    localparam int PAY_KEEP = 30;

    localparam logic [23:0] ID_HEARTBEAT = 24'd0;
    localparam logic [23:0] ID_GPS_RAW = 24'd24;
    localparam logic [23:0] ID_ATTITUDE = 24'd30;
    localparam logic [23:0] ID_GLOBAL_POS = 24'd33;
    localparam logic [23:0] ID_STREAM_REQ = 24'd66;

    localparam logic [4:0] FC_NONE = 5'd0;
    localparam logic [4:0] FC_PEER = 5'd1;
    localparam logic [4:0] FC_ATT_TIME = 5'd2;
    localparam logic [4:0] FC_ROLL = 5'd3;
    localparam logic [4:0] FC_PITCH = 5'd4;
    localparam logic [4:0] FC_YAW = 5'd5;
    localparam logic [4:0] FC_ATT_VALID = 5'd6;
    localparam logic [4:0] FC_FIX = 5'd7;
    localparam logic [4:0] FC_LAT = 5'd8;
    localparam logic [4:0] FC_LON = 5'd9;
    localparam logic [4:0] FC_ALT = 5'd10;
    localparam logic [4:0] FC_COURSE = 5'd11;
    localparam logic [4:0] FC_SATS = 5'd12;
    localparam logic [4:0] FC_GPS_VALID = 5'd13;
    localparam logic [4:0] FC_REL_ALT = 5'd14;
    localparam logic [4:0] FC_VEL_X = 5'd15;
    localparam logic [4:0] FC_VEL_Y = 5'd16;
    localparam logic [4:0] FC_VEL_Z = 5'd17;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_HEARTBEAT,
        KIND_ATTITUDE,
        KIND_GPS_RAW,
        KIND_GLOBAL_POS
    } kind_t;

    typedef struct packed {
        logic                         status;
        logic [23:0]                  msg_id;
        kind_t                        kind;
        logic [7:0]                   peer;
        logic [PAY_KEEP-1:0][7:0]     pay;
        logic [31:0]                  good_cnt;
        logic [31:0]                  bad_cnt;
    } frame_desc_t;

    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'd0};
        return {8'd0, crc[15:8]} ^ {t, 8'd0} ^ {5'd0, t, 3'd0} ^ {12'd0, t[7:4]};
    endfunction

    function automatic logic [7:0] extra_byte(input logic [23:0] id);
        case (id)
            ID_HEARTBEAT:  return 8'd50;
            ID_GPS_RAW:    return 8'd24;
            ID_ATTITUDE:   return 8'd39;
            ID_GLOBAL_POS: return 8'd104;
            ID_STREAM_REQ: return 8'd148;
            default:       return 8'd0;
        endcase
    endfunction

endpackage

@@ hdl/mfp_front.sv @@
// ----------------------------------------------------------------------------
// mfp_front
// byte hunter and frame collector: crc check, field capture, frame descriptor
// ----------------------------------------------------------------------------
module mfp_front #(
    parameter int FRAME_BUFFER_BYTES = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid_i,
    input  logic [7:0]           byte_i,
    output logic                 byte_ready_o,
    output logic                 push_o,
    output mfp_pkg::frame_desc_t desc_o,
    input  logic                 fifo_ready_i
);
    import mfp_pkg::*;

    localparam int HW = $clog2(FRAME_BUFFER_BYTES + 1);
    localparam int CW = (HW > 10) ? HW + 1 : 11;
    localparam logic [HW-1:0] FULL_AT = HW'(FRAME_BUFFER_BYTES);

    logic [HW-1:0]  held_reg, held_next;
    logic [9:0]     fexp_reg, fexp_next;
    logic [3:0]     hs_reg, hs_next;
    logic [15:0]    crc_reg, crc_next;
    logic           v1_reg, v1_next;
    logic [7:0]     plen_reg, plen_next;
    logic [23:0]    id_reg, id_next;
    logic [7:0]     peer_reg, peer_next;
    logic [7:0]     rxlo_reg, rxlo_next;
    logic [PAY_KEEP-1:0][7:0] pay_reg, pay_next;
    logic [31:0]    good_reg, good_next, bad_reg, bad_next;

    logic           accept, idle, done;
    logic [3:0]     hs_eff;
    logic [15:0]    crc_eff, crc_fin;
    logic [9:0]     fexp_eff;
    logic [CW-1:0]  idx_w, fexp_w, jj;
    logic           crc_ok;
    frame_desc_t    desc;

    assign byte_ready_o = fifo_ready_i;
    assign accept = byte_valid_i && byte_ready_o;
    assign idle = (held_reg == '0);

    always_comb begin
        held_next = held_reg;
        fexp_next = fexp_reg;
        hs_next = hs_reg;
        crc_next = crc_reg;
        v1_next = v1_reg;
        plen_next = plen_reg;
        id_next = id_reg;
        peer_next = peer_reg;
        rxlo_next = rxlo_reg;
        pay_next = pay_reg;
        good_next = good_reg;
        bad_next = bad_reg;
        done = 1'b0;
        crc_ok = 1'b0;
        hs_eff = hs_reg;
        crc_eff = crc_reg;
        fexp_eff = fexp_reg;
        crc_fin = crc_reg;
        idx_w = CW'(held_reg);
        jj = '0;
        fexp_w = '0;
        if (accept && !(idle && byte_i != START_V1 && byte_i != START_V2)) begin
            if (idle) begin
                hs_eff = (byte_i == START_V1) ? HDR_V1 : HDR_V2;
                crc_eff = CRC_INIT;
            end
            hs_next = hs_eff;
            crc_next = crc_eff;
            if (held_reg >= FULL_AT) begin
                held_next = '0;
                fexp_next = '0;
            end else begin
                held_next = held_reg + 1'b1;
                if (idx_w == CW'(0)) v1_next = (byte_i == START_V1);
                if (idx_w == CW'(1)) begin
                    fexp_eff = 10'(hs_eff) + 10'(byte_i) + 10'd2;
                    plen_next = byte_i;
                end
                fexp_w = CW'(fexp_eff);
                if (idx_w >= CW'(1) && fexp_eff != '0 && idx_w < fexp_w - CW'(2))
                    crc_next = crc_step(byte_i, crc_eff);
                fexp_next = fexp_eff;
                // header capture
                if (v1_reg && idx_w == CW'(5)) id_next = {16'd0, byte_i};
                if (!v1_reg && idx_w == CW'(7)) id_next[7:0] = byte_i;
                if (!v1_reg && idx_w == CW'(8)) id_next[15:8] = byte_i;
                if (!v1_reg && idx_w == CW'(9)) id_next[23:16] = byte_i;
                if ((v1_reg && idx_w == CW'(3)) || (!v1_reg && idx_w == CW'(5)))
                    peer_next = byte_i;
                // payload capture of the decoded window
                jj = idx_w - CW'(hs_eff);
                if (idx_w >= CW'(hs_eff) && jj < CW'(PAY_KEEP))
                    pay_next[jj[4:0]] = byte_i;
                if (fexp_eff != '0 && idx_w == fexp_w - CW'(2)) rxlo_next = byte_i;
                if (fexp_eff != '0 && idx_w + CW'(1) >= fexp_w) begin
                    done = 1'b1;
                    crc_fin = crc_step(extra_byte(id_reg), crc_eff);
                    crc_ok = ({byte_i, rxlo_reg} == crc_fin);
                    held_next = '0;
                    fexp_next = '0;
                    crc_next = CRC_INIT;
                    if (crc_ok) good_next = good_reg + 32'd1;
                    else bad_next = bad_reg + 32'd1;
                end
            end
        end
    end

    always_comb begin
        desc.status = !crc_ok;
        desc.msg_id = id_reg;
        desc.peer = peer_reg;
        desc.pay = pay_next;
        desc.good_cnt = good_next;
        desc.bad_cnt = bad_next;
        desc.kind = KIND_NONE;
        if (crc_ok) begin
            if (id_reg == ID_HEARTBEAT) desc.kind = KIND_HEARTBEAT;
            else if (id_reg == ID_ATTITUDE && plen_reg >= 8'd16) desc.kind = KIND_ATTITUDE;
            else if (id_reg == ID_GPS_RAW && plen_reg >= 8'd30) desc.kind = KIND_GPS_RAW;
            else if (id_reg == ID_GLOBAL_POS && plen_reg >= 8'd28)
                desc.kind = KIND_GLOBAL_POS;
        end
    end

    assign push_o = done;
    assign desc_o = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            fexp_reg <= '0;
            hs_reg <= '0;
            crc_reg <= CRC_INIT;
            v1_reg <= 1'b0;
            good_reg <= '0;
            bad_reg <= '0;
        end else begin
            held_reg <= held_next;
            fexp_reg <= fexp_next;
            hs_reg <= hs_next;
            crc_reg <= crc_next;
            v1_reg <= v1_next;
            good_reg <= good_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        plen_reg <= plen_next;
        id_reg <= id_next;
        peer_reg <= peer_next;
        rxlo_reg <= rxlo_next;
        pay_reg <= pay_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= FULL_AT) else $error("byte count beyond buffer");
    a_fexp_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (fexp_reg != '0) |-> (held_reg >= HW'(2))) else $error("length without header");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_o |-> fifo_ready_i) else $error("push into full queue");

endmodule

@@ hdl/mfp_fifo.sv @@
// ----------------------------------------------------------------------------
// mfp_fifo
// two-entry descriptor queue between the collector and the emitter
// ----------------------------------------------------------------------------
module mfp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_i,
    input  logic [WIDTH-1:0] data_i,
    output logic             ready_o,
    input  logic             pop_i,
    output logic             valid_o,
    output logic [WIDTH-1:0] data_o
);
    logic [1:0][WIDTH-1:0] mem_reg;
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign ready_o = (cnt_reg != 2'd2);
    assign valid_o = (cnt_reg != 2'd0);
    assign data_o = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push_i) mem_reg[wp_reg] <= data_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push_i) wp_reg <= !wp_reg;
            if (pop_i) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push_i} - {1'b0, pop_i};
        end
    end

endmodule

@@ hdl/mfp_back.sv @@
// ----------------------------------------------------------------------------
// mfp_back
// field emitter: walks one frame descriptor into tagged result beats
// ----------------------------------------------------------------------------
module mfp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid_i,
    input  mfp_pkg::frame_desc_t head_i,
    output logic                 pop_o,
    output logic                 out_valid_o,
    input  logic                 out_ready_i,
    output logic [121:0]         out_data_o,
    output logic [4:0]           out_code_o,
    output logic                 out_last_o
);
    import mfp_pkg::*;

    logic [3:0]   k_reg;
    logic         mv_reg;
    logic [121:0] data_reg;
    logic [4:0]   code_reg;
    logic         last_reg;

    logic [3:0]   n_items;
    logic [4:0]   code;
    logic [32:0]  val;
    logic         load, last;
    logic [31:0]  lat, lon;

    function automatic logic [31:0] w32(input logic [PAY_KEEP-1:0][7:0] p, input int o);
        return {p[o+3], p[o+2], p[o+1], p[o]};
    endfunction

    function automatic logic [15:0] w16(input logic [PAY_KEEP-1:0][7:0] p, input int o);
        return {p[o+1], p[o]};
    endfunction

    always_comb begin
        code = FC_NONE;
        val = '0;
        n_items = 4'd1;
        lat = '0;
        lon = '0;
        case (head_i.kind)
            KIND_HEARTBEAT: begin
                code = FC_PEER;
                val = {25'd0, head_i.peer};
            end
            KIND_ATTITUDE: begin
                n_items = 4'd5;
                case (k_reg)
                    4'd0: begin code = FC_ATT_TIME; val = {1'b0, w32(head_i.pay, 0)}; end
                    4'd1: begin code = FC_ROLL; val = {1'b0, w32(head_i.pay, 4)}; end
                    4'd2: begin code = FC_PITCH; val = {1'b0, w32(head_i.pay, 8)}; end
                    4'd3: begin code = FC_YAW; val = {1'b0, w32(head_i.pay, 12)}; end
                    default: begin code = FC_ATT_VALID; val = 33'd1; end
                endcase
            end
            KIND_GPS_RAW: begin
                n_items = 4'd7;
                lat = w32(head_i.pay, 8);
                lon = w32(head_i.pay, 12);
                case (k_reg)
                    4'd0: begin code = FC_FIX; val = {25'd0, head_i.pay[28]}; end
                    4'd1: begin code = FC_LAT; val = {lat[31], lat}; end
                    4'd2: begin code = FC_LON; val = {lon[31], lon}; end
                    4'd3: begin
                        code = FC_ALT;
                        val = {head_i.pay[19][7], w32(head_i.pay, 16)};
                    end
                    4'd4: begin code = FC_COURSE; val = {17'd0, w16(head_i.pay, 26)}; end
                    4'd5: begin code = FC_SATS; val = {25'd0, head_i.pay[29]}; end
                    default: begin
                        code = FC_GPS_VALID;
                        val = {32'd0, (head_i.pay[28] >= 8'd2) && lat != '0 && lon != '0};
                    end
                endcase
            end
            KIND_GLOBAL_POS: begin
                n_items = 4'd9;
                lat = w32(head_i.pay, 4);
                lon = w32(head_i.pay, 8);
                case (k_reg)
                    4'd0: begin code = FC_LAT; val = {lat[31], lat}; end
                    4'd1: begin code = FC_LON; val = {lon[31], lon}; end
                    4'd2: begin
                        code = FC_ALT;
                        val = {head_i.pay[15][7], w32(head_i.pay, 12)};
                    end
                    4'd3: begin
                        code = FC_REL_ALT;
                        val = {head_i.pay[19][7], w32(head_i.pay, 16)};
                    end
                    4'd4: begin
                        code = FC_VEL_X;
                        val = {{17{head_i.pay[21][7]}}, w16(head_i.pay, 20)};
                    end
                    4'd5: begin
                        code = FC_VEL_Y;
                        val = {{17{head_i.pay[23][7]}}, w16(head_i.pay, 22)};
                    end
                    4'd6: begin
                        code = FC_VEL_Z;
                        val = {{17{head_i.pay[25][7]}}, w16(head_i.pay, 24)};
                    end
                    4'd7: begin code = FC_COURSE; val = {17'd0, w16(head_i.pay, 26)}; end
                    default: begin
                        code = FC_GPS_VALID;
                        val = {32'd0, lat != '0 && lon != '0};
                    end
                endcase
            end
            default: begin
                code = FC_NONE;
                val = '0;
            end
        endcase
    end

    assign load = head_valid_i && (!mv_reg || out_ready_i);
    assign last = (k_reg == n_items - 4'd1);
    assign pop_o = load && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            if (load) k_reg <= last ? 4'd0 : k_reg + 4'd1;
            if (load) mv_reg <= 1'b1;
            else if (out_ready_i) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {head_i.bad_cnt, head_i.good_cnt, val, head_i.msg_id, head_i.status};
            code_reg <= code;
            last_reg <= last;
        end
    end

    assign out_valid_o = mv_reg;
    assign out_data_o = data_reg;
    assign out_code_o = code_reg;
    assign out_last_o = last_reg;

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= 4'd8) else $error("field index out of range");
    a_idle_k: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid_i |-> (k_reg == 4'd0)) else $error("index left over without frame");
    a_pop_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_o |=> (mv_reg && last_reg)) else $error("frame popped without last beat");

endmodule

@@ hdl/mavlink_frame_parser.sv @@
// ----------------------------------------------------------------------------
// mavlink_frame_parser
// v1/v2 link frame parser with x25 crc check and tagged field output
// ----------------------------------------------------------------------------
// path: the first result beat of a frame follows the acceptance of the last byte
//   of the frame through the queue write, then the output register
// throughput: one byte per cycle in, one result beat per cycle out while m_tready
//   is high; a frame gives 1 to 9 beats, a two-entry frame queue decouples the
//   two sides and byte intake stalls only while the queue holds two frames
// reset: aresetn synchronous active low, clears hunt state, crc and counters
// ----------------------------------------------------------------------------
module mavlink_frame_parser #(
    parameter int FRAME_BUFFER_BYTES = 512
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] frame_status, [24:1] message_id, [57:25] field_value,
    // [89:58] good_count, [121:90] bad_count, [127:122] zero
    output logic [127:0] m_tdata,
    output logic [4:0]   m_tuser,   // [4:0] field_code
    output logic         m_tlast    // last_of_frame
);
    import mfp_pkg::*;

    // front to queue
    logic        push, fifo_ready;
    frame_desc_t desc_in;
    // queue to back
    logic        head_valid, pop;
    frame_desc_t head;
    logic [121:0] out_data;

    // hunts start bytes, tracks length and crc, captures decoded fields
    mfp_front #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .byte_valid_i(s_tvalid), .byte_i(s_tdata), .byte_ready_o(s_tready),
        .push_o(push), .desc_o(desc_in), .fifo_ready_i(fifo_ready)
    );

    // short frame queue so byte intake waits on field emission only while it holds two frames
    mfp_fifo #(.WIDTH($bits(frame_desc_t))) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push_i(push), .data_i(desc_in), .ready_o(fifo_ready),
        .pop_i(pop), .valid_o(head_valid), .data_o(head)
    );

    // expands each frame into its result beats behind an output register
    mfp_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
        .out_valid_o(m_tvalid), .out_ready_i(m_tready),
        .out_data_o(out_data), .out_code_o(m_tuser), .out_last_o(m_tlast)
    );

    assign m_tdata = {6'd0, out_data};

endmodule

@@ verif/mavlink_frame_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mavlink_frame_parser_test
// self-checking bench for the link frame parser: builds v1/v2 frames with
// good and corrupted crc plus line noise, predicts the tagged field beats
// and compares every result beat in order
// ----------------------------------------------------------------------------
module mavlink_frame_parser_test;
    import mfp_pkg::*;

    // one predicted result beat
    typedef struct {
        logic        status;
        logic [23:0] msg_id;
        logic [4:0]  code;
        logic [32:0] value;
        logic        last;
        logic [31:0] good_cnt;
        logic [31:0] bad_cnt;
    } field_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;

    mavlink_frame_parser u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    logic [7:0]  link_bytes[$];      // bytes waiting to be sent
    field_beat_t expected_fields[$]; // predicted beats, oldest first
    int          errors = 0;
    bit          quiet = 1'b0;       // no idling on either side
    int          hold_off = 0;       // receiver long stall counter
    bit          stall_req = 1'b0;   // asks for one long receiver stall
    bit          stim_done = 1'b0;

    // parser state mirror
    logic [7:0]  fstore[512];
    int          held = 0;
    int          need = 0;
    int          hdr = 0;
    logic [15:0] crc_acc = 16'hFFFF;
    logic [31:0] n_good = 0;
    logic [31:0] n_bad = 0;

    function automatic logic [15:0] x25(logic [7:0] b, logic [15:0] c);
        logic [7:0] t;
        t = b ^ c[7:0];
        t = t ^ (t << 4);
        return (c >> 8) ^ ({8'd0, t} << 8) ^ ({8'd0, t} << 3) ^ ({8'd0, t} >> 4);
    endfunction

    function automatic logic [7:0] link_extra(logic [23:0] id);
        case (id)
            ID_HEARTBEAT:  return 8'd50;
            ID_GPS_RAW:    return 8'd24;
            ID_ATTITUDE:   return 8'd39;
            ID_GLOBAL_POS: return 8'd104;
            ID_STREAM_REQ: return 8'd148;
            default:       return 8'd0;
        endcase
    endfunction

    function automatic logic [31:0] get32(int i);
        return {fstore[i+3], fstore[i+2], fstore[i+1], fstore[i]};
    endfunction

    function automatic logic [15:0] get16(int i);
        return {fstore[i+1], fstore[i]};
    endfunction

    task automatic push_field(logic st, logic [23:0] id, logic [4:0] code, logic [32:0] v);
        field_beat_t f;
        f.status = st; f.msg_id = id; f.code = code; f.value = v; f.last = 1'b0;
        f.good_cnt = n_good; f.bad_cnt = n_bad;
        expected_fields.push_back(f);
    endtask

    function automatic logic [32:0] sext32(logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [32:0] sext16(logic [15:0] v);
        return {{17{v[15]}}, v};
    endfunction

    // predicts the beats caused by one accepted byte
    task automatic parse_byte(logic [7:0] b);
        int idx, p, plen, n0;
        logic [23:0] id;
        logic [15:0] crc, rx;
        logic [31:0] lat, lon;
        logic [7:0] fix;
        if (held == 0) begin
            if (b != START_V1 && b != START_V2) return;
            hdr = (b == START_V1) ? 6 : 10;
            crc_acc = 16'hFFFF;
        end
        idx = held;
        fstore[idx] = b;
        held = idx + 1;
        if (idx == 1) need = hdr + int'(b) + 2;
        if (idx >= 1 && need != 0 && idx < need - 2) crc_acc = x25(b, crc_acc);
        if (need == 0 || held < need) return;
        id = (fstore[0] == START_V1) ? {16'd0, fstore[5]} : {fstore[9], fstore[8], fstore[7]};
        crc = x25(link_extra(id), crc_acc);
        rx = get16(need - 2);
        p = hdr;
        plen = int'(fstore[1]);
        held = 0; need = 0; crc_acc = 16'hFFFF;
        n0 = expected_fields.size();
        if (rx != crc) begin
            n_bad++;
            push_field(1'b1, id, FC_NONE, 33'd0);
        end else begin
            n_good++;
            if (id == ID_HEARTBEAT)
                push_field(1'b0, id, FC_PEER, {25'd0, fstore[(hdr == 6) ? 3 : 5]});
            if (id == ID_ATTITUDE && plen >= 16) begin
                push_field(1'b0, id, FC_ATT_TIME, {1'b0, get32(p)});
                push_field(1'b0, id, FC_ROLL, {1'b0, get32(p + 4)});
                push_field(1'b0, id, FC_PITCH, {1'b0, get32(p + 8)});
                push_field(1'b0, id, FC_YAW, {1'b0, get32(p + 12)});
                push_field(1'b0, id, FC_ATT_VALID, 33'd1);
            end else if (id == ID_GPS_RAW && plen >= 30) begin
                fix = fstore[p + 28]; lat = get32(p + 8); lon = get32(p + 12);
                push_field(1'b0, id, FC_FIX, {25'd0, fix});
                push_field(1'b0, id, FC_LAT, sext32(lat));
                push_field(1'b0, id, FC_LON, sext32(lon));
                push_field(1'b0, id, FC_ALT, sext32(get32(p + 16)));
                push_field(1'b0, id, FC_COURSE, {17'd0, get16(p + 26)});
                push_field(1'b0, id, FC_SATS, {25'd0, fstore[p + 29]});
                push_field(1'b0, id, FC_GPS_VALID,
                           {32'd0, (fix >= 8'd2 && lat != 32'd0 && lon != 32'd0)});
            end else if (id == ID_GLOBAL_POS && plen >= 28) begin
                lat = get32(p + 4); lon = get32(p + 8);
                push_field(1'b0, id, FC_LAT, sext32(lat));
                push_field(1'b0, id, FC_LON, sext32(lon));
                push_field(1'b0, id, FC_ALT, sext32(get32(p + 12)));
                push_field(1'b0, id, FC_REL_ALT, sext32(get32(p + 16)));
                push_field(1'b0, id, FC_VEL_X, sext16(get16(p + 20)));
                push_field(1'b0, id, FC_VEL_Y, sext16(get16(p + 22)));
                push_field(1'b0, id, FC_VEL_Z, sext16(get16(p + 24)));
                push_field(1'b0, id, FC_COURSE, {17'd0, get16(p + 26)});
                push_field(1'b0, id, FC_GPS_VALID, {32'd0, (lat != 32'd0 && lon != 32'd0)});
            end
            if (expected_fields.size() == n0) push_field(1'b0, id, FC_NONE, 33'd0);
        end
        expected_fields[expected_fields.size() - 1].last = 1'b1;
    endtask

    // queues one frame; payload bytes random unless fill given, crc optionally broken
    task automatic add_frame(bit v2, logic [23:0] id, int plen, bit bad_crc, int fill);
        logic [7:0] fr[$];
        logic [15:0] c;
        int i;
        fr.push_back(v2 ? START_V2 : START_V1);
        fr.push_back(plen[7:0]);
        if (v2) begin
            fr.push_back(8'($urandom_range(0, 255))); fr.push_back(8'($urandom_range(0, 255)));
        end
        for (i = 0; i < 3; i++) fr.push_back(8'($urandom_range(0, 255)));
        if (v2) begin
            fr.push_back(id[7:0]); fr.push_back(id[15:8]); fr.push_back(id[23:16]);
        end else begin
            fr.push_back(id[7:0]);
        end
        for (i = 0; i < plen; i++)
            fr.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
        c = 16'hFFFF;
        for (i = 1; i < fr.size(); i++) c = x25(fr[i], c);
        c = x25(link_extra(id), c);
        if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        foreach (fr[k]) link_bytes.push_back(fr[k]);
    endtask

    function automatic logic [23:0] pick_id();
        case ($urandom_range(0, 6))
            0: return ID_HEARTBEAT;
            1: return ID_ATTITUDE;
            2: return ID_GPS_RAW;
            3: return ID_GLOBAL_POS;
            4: return ID_STREAM_REQ;
            5: return 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(0, 16777215));
        endcase
    endfunction

    // driver: one byte offered per beat, random idling except in quiet stretches
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (link_bytes.size() > 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= link_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter, started on request from the stimulus
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off <= 0;
        end else if (stall_req && hold_off == 0) begin
            hold_off <= 400;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor: compares each accepted result beat with the oldest prediction
    always @(posedge aclk) begin
        field_beat_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_fields.pop_front();
                    if (m_tdata[0] !== e.status) begin
                        $error("frame_status exp %0h got %0h", e.status, m_tdata[0]); errors++;
                    end
                    if (m_tdata[24:1] !== e.msg_id) begin
                        $error("message_id exp %0h got %0h", e.msg_id, m_tdata[24:1]); errors++;
                    end
                    if (m_tuser !== e.code) begin
                        $error("field_code exp %0d got %0d", e.code, m_tuser); errors++;
                    end
                    if (m_tdata[57:25] !== e.value) begin
                        $error("field_value exp %0h got %0h", e.value, m_tdata[57:25]); errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_of_frame exp %0d got %0d", e.last, m_tlast); errors++;
                    end
                    if (m_tdata[89:58] !== e.good_cnt) begin
                        $error("good_count exp %0d got %0d", e.good_cnt, m_tdata[89:58]);
                        errors++;
                    end
                    if (m_tdata[121:90] !== e.bad_cnt) begin
                        $error("bad_count exp %0d got %0d", e.bad_cnt, m_tdata[121:90]);
                        errors++;
                    end
                end
            end
            // long receiver stall while the sender keeps offering bytes
            if (hold_off > 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    initial begin
        int frames, kind;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: noise, heartbeat, attitude, bad crc and an unknown id
        link_bytes.push_back(8'h00); link_bytes.push_back(8'hFF);
        add_frame(1'b0, ID_HEARTBEAT, 9, 1'b0, -1);
        add_frame(1'b1, ID_ATTITUDE, 16, 1'b0, -1);
        add_frame(1'b0, ID_HEARTBEAT, 0, 1'b1, -1);
        add_frame(1'b1, 24'hFFFFFF, 0, 1'b0, -1);
        while (link_bytes.size() > 0) @(posedge aclk);
        // stretch without idling: both position messages and the zero-lat rule
        quiet = 1'b1;
        add_frame(1'b0, ID_GPS_RAW, 30, 1'b0, -1);
        add_frame(1'b1, ID_GLOBAL_POS, 28, 1'b0, 0);
        while (link_bytes.size() > 0) @(posedge aclk);
        quiet = 1'b0;
        // block fills up while the receiver stalls
        for (frames = 0; frames < 5; frames++)
            add_frame(frames[0], ID_HEARTBEAT, 0, 1'b0, -1);
        stall_req = 1'b1;
        wait (hold_off > 0);
        stall_req = 1'b0;
        while (link_bytes.size() > 0) @(posedge aclk);
        // a few random frames, some corrupted and some noise
        for (frames = 0; frames < 3; frames++) begin
            kind = int'($urandom_range(0, 99));
            if (kind < 10) begin
                repeat ($urandom_range(1, 5)) link_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                add_frame(1'($urandom_range(0, 1)), pick_id(), int'($urandom_range(0, 6)),
                          kind < 30, -1);
            end
        end
        while (link_bytes.size() > 0 || s_tvalid) @(posedge aclk);
        stim_done = 1'b1;
    end

    // end of run once all predictions have been matched
    initial begin
        wait (stim_done);
        while (expected_fields.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
